FILE: rtl/core/pcma_pkg.sv
// Package with the sizes, types and field layout of the per-channel moving average core.
`default_nettype none

package pcma_pkg;

  localparam int unsigned CHANNELS = 10;
  localparam int unsigned WINDOW   = 16;

  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 16;

  localparam int unsigned CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PTR_W    = $clog2(WINDOW);
  localparam int unsigned FILL_W   = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W    = $clog2(WINDOW * 4095 + 1);
  localparam int unsigned RING_DEPTH = CHANNELS * WINDOW;
  localparam int unsigned RING_AW  = $clog2(RING_DEPTH);

  // The divider retires this many quotient bits per clock.
  localparam int unsigned DIV_STEP_BITS = 4;
  localparam int unsigned DIV_CYCLES    = (SUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned DIV_W         = DIV_CYCLES * DIV_STEP_BITS;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_CYCLES);
  localparam int unsigned REM_W         = FILL_W + 1;

  typedef struct packed {
    logic [PTR_W-1:0]  ptr;
    logic [SUM_W-1:0]  sum;
    logic [FILL_W-1:0] fill;
  } chan_st_t;

  localparam int unsigned CHAN_ST_W = $bits(chan_st_t);

endpackage

`default_nettype wire

FILE: rtl/core/pcma_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module pcma_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/per_channel_moving_average_core.sv
// Per-channel sliding-window moving average over converter samples.
// A filtered transaction passes through S_CHAN, S_RING, S_DIV and S_OUT after acceptance;
// a bypassed transaction goes straight to S_OUT, where the result and output valid are registered.
// A new transaction is taken only once the last has left S_OUT, which holds while the output is
// stalled; filtered transactions are further held by the two dependent memory reads and the
// iterative divider, which retires four quotient bits per cycle.
// Reset: clears control state and the per-channel valid bits; no clearing pass is needed.
`default_nettype none

module per_channel_moving_average_core
  import pcma_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [S_DATA_W-1:0] s_axis_tdata_i,  // [3:0] channel, [15:4] sample
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic      [M_DATA_W-1:0] m_axis_tdata_o   // [11:0] average, [15:12] zero
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAN,
    S_RING,
    S_DIV,
    S_OUT
  } state_e;

  state_e               state_q, state_d;
  logic                 m_valid_q, m_valid_d;
  logic [CHANNELS-1:0]  chan_vld_q, chan_vld_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  logic [CHAN_W-1:0]    ch_q;
  logic [SAMPLE_W-1:0]  smp_q;
  logic                 byp_q;
  chan_st_t             ent_q;
  logic [RING_AW-1:0]   ring_addr_q;
  logic [DIV_W-1:0]     dq_q, dq_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [FILL_W-1:0]    dvs_q;
  logic [SAMPLE_W-1:0]  avg_q;

  logic                 s_acc;
  logic                 out_free;
  logic                 in_bypass;
  logic [CHAN_W-1:0]    in_ch;
  logic [SAMPLE_W-1:0]  in_smp;

  chan_st_t             chan_rdata;
  chan_st_t             chan_cur;
  chan_st_t             chan_wdata;
  logic                 chan_we;
  logic [SAMPLE_W-1:0]  ring_rdata;
  logic [SAMPLE_W-1:0]  old_smp;
  logic [SUM_W-1:0]     new_sum;
  logic [FILL_W-1:0]    fill_inc;
  logic [PTR_W-1:0]     ptr_inc;
  logic [RING_AW-1:0]   ring_addr;

  assign in_ch     = s_axis_tdata_i[CHAN_W-1:0];
  assign in_smp    = s_axis_tdata_i[CHAN_W +: SAMPLE_W];
  assign in_bypass = ({1'b0, in_ch} >= (CHAN_W + 1)'(CHANNELS));

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_valid_q | m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = M_DATA_W'(avg_q);

  // Per-channel pointer, sum and fill count; a channel never written is taken as all zero through its valid bit.
  pcma_ram #(
    .Width(CHAN_ST_W),
    .Depth(CHANNELS)
  ) u_chan_ram (
    .clk_i  (clk_i),
    .we_i   (chan_we),
    .waddr_i(ch_q[CH_AW-1:0]),
    .wdata_i(chan_wdata),
    .raddr_i(in_ch[CH_AW-1:0]),
    .rdata_o(chan_rdata)
  );

  pcma_ram #(
    .Width(SAMPLE_W),
    .Depth(RING_DEPTH)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (chan_we),
    .waddr_i(ring_addr_q),
    .wdata_i(smp_q),
    .raddr_i(ring_addr),
    .rdata_o(ring_rdata)
  );

  assign chan_cur  = chan_vld_q[ch_q[CH_AW-1:0]] ? chan_rdata : '0;
  assign ring_addr = RING_AW'(ch_q) * RING_AW'(WINDOW) + RING_AW'(chan_cur.ptr);

  // While the ring is filling, the slot under the pointer has never been written, so the
  // sample leaving the window counts as zero.
  assign old_smp  = (ent_q.fill == FILL_W'(WINDOW)) ? ring_rdata : '0;
  assign new_sum  = ent_q.sum - SUM_W'(old_smp) + SUM_W'(smp_q);
  assign fill_inc = (ent_q.fill == FILL_W'(WINDOW)) ? ent_q.fill : ent_q.fill + 1'b1;
  assign ptr_inc  = (ent_q.ptr == PTR_W'(WINDOW - 1)) ? '0 : ent_q.ptr + 1'b1;

  assign chan_we         = (state_q == S_RING);
  assign chan_wdata.ptr  = ptr_inc;
  assign chan_wdata.sum  = new_sum;
  assign chan_wdata.fill = fill_inc;

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    logic [REM_W-1:0] r;
    logic [DIV_W-1:0] q;
    r = rem_q;
    q = dq_q;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      r = {r[REM_W-2:0], q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (r >= REM_W'(dvs_q)) begin
        r    = r - REM_W'(dvs_q);
        q[0] = 1'b1;
      end
    end
    rem_d = r;
    dq_d  = q;
  end

  always_comb begin
    state_d    = state_q;
    m_valid_d  = m_valid_q & ~m_axis_tready_i;
    chan_vld_d = chan_vld_q;
    cnt_d      = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          state_d = in_bypass ? S_OUT : S_CHAN;
        end
      end
      S_CHAN: begin
        state_d = S_RING;
      end
      S_RING: begin
        chan_vld_d[ch_q[CH_AW-1:0]] = 1'b1;
        cnt_d   = DIV_CNT_W'(DIV_CYCLES - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_valid_q  <= 1'b0;
      chan_vld_q <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      m_valid_q  <= m_valid_d;
      chan_vld_q <= chan_vld_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      ch_q  <= in_ch;
      smp_q <= in_smp;
      byp_q <= in_bypass;
    end
    if (state_q == S_CHAN) begin
      ent_q       <= chan_cur;
      ring_addr_q <= ring_addr;
    end
    if (state_q == S_RING) begin
      dq_q  <= DIV_W'(new_sum);
      rem_q <= '0;
      dvs_q <= fill_inc;
    end else if (state_q == S_DIV) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
    if ((state_q == S_OUT) && out_free) begin
      avg_q <= byp_q ? smp_q : dq_q[SAMPLE_W-1:0];
    end
  end

  // Only one transaction is in the block at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input accepted while a transaction is still in progress");

  // During filling the pointer must track the fill count, or the zero old sample is wrong.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_we && (chan_wdata.fill < FILL_W'(WINDOW)) |-> chan_wdata.ptr == PTR_W'(chan_wdata.fill))
    else $error("write pointer and fill count disagree while filling");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_we |-> (chan_wdata.fill != '0) && (chan_wdata.fill <= FILL_W'(WINDOW)))
    else $error("fill count out of range");

  // A finished division leaves a remainder below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && ($past(state_q) == S_DIV) |-> rem_q < REM_W'(dvs_q))
    else $error("divider remainder not reduced");

  // A result waiting on the output is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_axis_tready_i |=> m_valid_q && $stable(avg_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: bench/per_channel_moving_average_core_tb.sv
// Self-checking bench for the per-channel moving average core, driven with random flow control.
module per_channel_moving_average_core_tb;
  import pcma_pkg::*;

  // Tracks each channel's window, forecasts the average of every accepted transaction
  // and checks the outputs against that forecast in order.
  class window_mean_tracker;
    bit [SAMPLE_W-1:0] ring [CHANNELS][WINDOW];
    bit [PTR_W-1:0]    wr_ptr [CHANNELS];
    bit [SUM_W-1:0]    ring_sum [CHANNELS];
    bit [FILL_W-1:0]   fill [CHANNELS];
    bit [SAMPLE_W-1:0] pending_means [$];
    int unsigned       errors;

    function void note_sample(bit [CHAN_W-1:0] chan, bit [SAMPLE_W-1:0] smp);
      bit [PTR_W-1:0] p;
      if (chan >= CHANNELS) begin
        pending_means.push_back(smp);
        return;
      end
      p = wr_ptr[chan];
      // The outgoing entry is zero while the ring is still filling.
      ring_sum[chan] = ring_sum[chan] - ring[chan][p] + smp;
      ring[chan][p] = smp;
      wr_ptr[chan] = (p == WINDOW - 1) ? '0 : p + 1'b1;
      if (fill[chan] < WINDOW) fill[chan]++;
      pending_means.push_back(SAMPLE_W'(ring_sum[chan] / fill[chan]));
    endfunction

    function void check_average(logic [SAMPLE_W-1:0] got);
      bit [SAMPLE_W-1:0] want;
      if (pending_means.size() == 0) begin
        errors++;
        if (errors <= 10) $display("average %0d arrived with no transaction outstanding", got);
        return;
      end
      want = pending_means.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("average mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;  // [3:0] channel, [15:4] sample
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;       // [11:0] average, [15:12] zero

  // While set, neither side inserts idle cycles.
  bit steady = 1'b0;

  window_mean_tracker tracker = new();

  per_channel_moving_average_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("per_channel_moving_average_core test failed");
    $finish;
  end

  // Output side: check on each completed transaction, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_average(m_axis_tdata[SAMPLE_W-1:0]);
    end
    m_axis_tready <= steady || ($urandom_range(99) >= 36);
  end

  task automatic send_item(input bit [CHAN_W-1:0] chan, input bit [SAMPLE_W-1:0] smp);
    while (!steady && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= S_DATA_W'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {smp, chan};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_sample(chan, smp);
  endtask

  initial begin
    int unsigned       sent;
    int unsigned       burst;
    bit [CHAN_W-1:0]   chan;
    bit [SAMPLE_W-1:0] smp;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bypassed channels at both ends of the range, with extreme and alternating samples.
    send_item(4'd15, 12'hFFF);
    send_item(CHAN_W'(CHANNELS), 12'h000);
    send_item(4'd12, 12'hAAA);
    send_item(4'd13, 12'h555);
    // A mean of 1.5 must truncate to 1 while the ring fills.
    send_item(4'd3, 12'd1);
    send_item(4'd3, 12'd2);
    send_item(CHAN_W'(CHANNELS - 1), 12'd0);
    // Full-scale samples fill the ring, reach the largest sum and wrap the pointer.
    repeat (WINDOW + 2) send_item(4'd0, 12'hFFF);

    sent = 0;
    while (sent < 600) begin
      if ($urandom_range(4) == 0) begin
        chan  = CHAN_W'($urandom_range(15, CHANNELS));
        burst = $urandom_range(1, 3);
      end else begin
        chan  = CHAN_W'($urandom_range(CHANNELS - 1));
        burst = $urandom_range(1, 2 * WINDOW);
      end
      repeat (burst) begin
        steady = (sent >= 200 && sent < 350);
        case ($urandom_range(9))
          0:       smp = '0;
          1:       smp = '1;
          default: smp = SAMPLE_W'($urandom);
        endcase
        send_item(chan, smp);
        sent++;
      end
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (tracker.pending_means.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("per_channel_moving_average_core test passed");
    end else begin
      $display("per_channel_moving_average_core test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/pcma_pkg.sv
rtl/core/pcma_ram.sv
rtl/core/per_channel_moving_average_core.sv
bench/per_channel_moving_average_core_tb.sv
